// File: sv/nwps_pkg.sv
// nwps_pkg: shared types, register codes and lookup tables for the
// note word to psg settings block; no dependencies
package nwps_pkg;

  localparam int PADDR_W = 5;
  localparam int NOTE_LAST = 56;
  localparam int SEMI_MAX = 95;
  localparam logic [7:0] MIXER_RESET = 8'd63;

  localparam logic [2:0] REG_TRANSPOSE_A = 3'd0;
  localparam logic [2:0] REG_TRANSPOSE_B = 3'd1;
  localparam logic [2:0] REG_TRANSPOSE_C = 3'd2;
  localparam logic [2:0] REG_LEVEL_A     = 3'd3;
  localparam logic [2:0] REG_LEVEL_B     = 3'd4;
  localparam logic [2:0] REG_LEVEL_C     = 3'd5;

  localparam logic [1:0] CH_A = 2'd0;
  localparam logic [1:0] CH_B = 2'd1;
  localparam logic [1:0] CH_C = 2'd2;

  typedef struct packed {
    logic [2:0][7:0] transpose;
    logic [2:0][6:0] level;
  } cfg_t;

  localparam logic [11:0] PERIOD_TAB [0:96] = '{
    12'd15, 12'd16, 12'd17, 12'd18, 12'd19, 12'd20, 12'd21, 12'd22, 12'd24, 12'd25,
    12'd27, 12'd28, 12'd30, 12'd32, 12'd34, 12'd36, 12'd38, 12'd40, 12'd42, 12'd45,
    12'd47, 12'd50, 12'd53, 12'd56, 12'd60, 12'd63, 12'd67, 12'd71, 12'd75, 12'd80,
    12'd84, 12'd89, 12'd95, 12'd100, 12'd106, 12'd113, 12'd119, 12'd127, 12'd134,
    12'd142, 12'd150, 12'd159, 12'd169, 12'd179, 12'd190, 12'd201, 12'd213, 12'd226,
    12'd239, 12'd253, 12'd268, 12'd284, 12'd301, 12'd319, 12'd338, 12'd358, 12'd379,
    12'd402, 12'd426, 12'd451, 12'd478, 12'd506, 12'd536, 12'd568, 12'd602, 12'd638,
    12'd676, 12'd716, 12'd759, 12'd804, 12'd852, 12'd903, 12'd956, 12'd1013, 12'd1073,
    12'd1136, 12'd1204, 12'd1276, 12'd1351, 12'd1432, 12'd1517, 12'd1607, 12'd1703,
    12'd1804, 12'd1911, 12'd2025, 12'd2145, 12'd2273, 12'd2408, 12'd2553, 12'd2703,
    12'd2864, 12'd3034, 12'd3214, 12'd3405, 12'd3608, 12'd3823
  };

  localparam logic [6:0] SCALE_TAB [0:56] = '{
    7'd0, 7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12, 7'd13, 7'd15, 7'd17, 7'd19,
    7'd20, 7'd22, 7'd24, 7'd25, 7'd27, 7'd29, 7'd31, 7'd32, 7'd34, 7'd36, 7'd37,
    7'd39, 7'd41, 7'd43, 7'd44, 7'd46, 7'd48, 7'd49, 7'd51, 7'd53, 7'd55, 7'd56,
    7'd58, 7'd60, 7'd61, 7'd63, 7'd65, 7'd67, 7'd68, 7'd70, 7'd72, 7'd73, 7'd75,
    7'd77, 7'd79, 7'd80, 7'd82, 7'd84, 7'd85, 7'd87, 7'd89, 7'd91, 7'd92, 7'd94,
    7'd96
  };

endpackage

// File: sv/nwps_if.sv
// nwps_if: handshake channels for note items in and settings items out
// no dependencies
interface nwps_note_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic [15:0] note_word;

  modport source (output valid, channel, note_word, input ready);
  modport sink (input valid, channel, note_word, output ready);
endinterface

interface nwps_psg_if;
  logic        valid;
  logic        ready;
  logic        is_noise_cmd;
  logic [11:0] tone_period;
  logic [3:0]  volume;
  logic [7:0]  mixer;
  logic [7:0]  noise_period;

  modport source (output valid, is_noise_cmd, tone_period, volume, mixer, noise_period,
                  input ready);
  modport sink (input valid, is_noise_cmd, tone_period, volume, mixer, noise_period,
                output ready);
endinterface

// File: sv/nwps_cfg.sv
// nwps_cfg: apb register file for channel transpose and level percent
// depends on nwps_pkg
module nwps_cfg import nwps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transpose <= '0;
      cfg.level     <= {3{7'd100}};
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TRANSPOSE_A: cfg.transpose[CH_A] <= pwdata[7:0];
        REG_TRANSPOSE_B: cfg.transpose[CH_B] <= pwdata[7:0];
        REG_TRANSPOSE_C: cfg.transpose[CH_C] <= pwdata[7:0];
        REG_LEVEL_A:     cfg.level[CH_A]     <= pwdata[6:0];
        REG_LEVEL_B:     cfg.level[CH_B]     <= pwdata[6:0];
        REG_LEVEL_C:     cfg.level[CH_C]     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRANSPOSE_A: prdata = {24'd0, cfg.transpose[CH_A]};
      REG_TRANSPOSE_B: prdata = {24'd0, cfg.transpose[CH_B]};
      REG_TRANSPOSE_C: prdata = {24'd0, cfg.transpose[CH_C]};
      REG_LEVEL_A:     prdata = {25'd0, cfg.level[CH_A]};
      REG_LEVEL_B:     prdata = {25'd0, cfg.level[CH_B]};
      REG_LEVEL_C:     prdata = {25'd0, cfg.level[CH_C]};
      default:         prdata = '0;
    endcase
  end

endmodule

// File: sv/nwps_pitch.sv
// nwps_pitch: note to semitone mapping and quarter-step period interpolation
// depends on nwps_pkg
module nwps_pitch import nwps_pkg::*; (
  input  logic [15:0] note_word,
  input  logic [7:0]  transpose,
  output logic [11:0] tone_period
);

  logic [5:0]        note;
  logic signed [9:0] semi_raw;
  logic [6:0]        semi;
  logic [6:0]        semi_up;
  logic [1:0]        frac;
  logic [13:0]       mix_sum;

  always_comb begin
    note = (note_word[7:2] > 6'(NOTE_LAST)) ? 6'(NOTE_LAST) : note_word[7:2];
    semi_raw = signed'({3'd0, SCALE_TAB[note]})
             - signed'({9'd0, note_word[14]})
             + signed'({9'd0, note_word[15]})
             - 10'(signed'(transpose));
    if (semi_raw < 0)
      semi = '0;
    else if (semi_raw > 10'(SEMI_MAX))
      semi = 7'(SEMI_MAX);
    else
      semi = semi_raw[6:0];
    semi_up = semi + 7'd1;
    frac    = note_word[1:0];
    mix_sum = 14'(PERIOD_TAB[semi] * (3'd4 - {1'b0, frac}))
            + 14'(PERIOD_TAB[semi_up] * frac);
    tone_period = mix_sum[13:2];
  end

endmodule

// File: sv/nwps_level.sv
// nwps_level: volume scaled by level percent, divided by one hundred
// and saturated at fifteen; depends on nwps_pkg
module nwps_level import nwps_pkg::*; (
  input  logic [3:0] vol_in,
  input  logic [6:0] level,
  output logic [3:0] volume
);

  logic [10:0] product;
  logic [14:0] above;

  // quotient by hundred as a count of thresholds passed
  always_comb begin
    product = 11'(vol_in * level);
    for (int k = 0; k < 15; k++) begin
      above[k] = product >= 11'(100 * (k + 1));
    end
    volume = 4'($countones(above));
  end

endmodule

// File: sv/note_word_to_psg_settings.sv
// note_word_to_psg_settings: top level, input register, settings register,
// mixer state; depends on nwps_pkg, nwps_if, nwps_cfg, nwps_pitch, nwps_level
//
//   port         dir   handshake          payload
//   note_in      in    valid/ready        channel, note_word
//   settings_out out   valid/ready        is_noise_cmd, tone_period, volume,
//                                         mixer, noise_period
//   apb          in    psel/penable       paddr, pwdata -> prdata
//
// items pass the input register, then the result register; one item per cycle
// sustained while results are taken; pitch and level logic sits between them
// the mixer byte updates as a tone item moves into the result register
// reset clears both valid flags and sets the mixer byte to its reset value
// a stalled result holds and the input register waits behind it
module note_word_to_psg_settings import nwps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  nwps_note_if.sink          note_in,
  nwps_psg_if.source         settings_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t        cfg;
  logic        s1_valid;
  logic [1:0]  s1_channel;
  logic [15:0] s1_word;
  logic        advance;
  logic        load;
  logic [1:0]  ch;
  logic        noise_cmd;
  logic [7:0]  mixer_byte;
  logic [7:0]  mixer_byte_next;
  logic [2:0]  ch_bit;
  logic [11:0] period;
  logic [3:0]  vol;
  logic        out_valid;

  nwps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance       = !out_valid || settings_out.ready;
  assign load          = s1_valid && advance;
  assign note_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (note_in.ready) begin
      s1_valid <= note_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (note_in.valid && note_in.ready) begin
      s1_channel <= note_in.channel;
      s1_word    <= note_in.note_word;
    end
  end

  // channel three behaves as channel two
  assign ch        = (s1_channel == 2'd3) ? CH_C : s1_channel;
  assign noise_cmd = s1_word[15] && s1_word[14];
  assign ch_bit    = 3'(1 << ch);

  always_comb begin
    mixer_byte_next = mixer_byte;
    if (s1_word[12]) begin
      mixer_byte_next[2:0] = mixer_byte[2:0] & ~ch_bit;
    end else begin
      mixer_byte_next[2:0] = mixer_byte[2:0] | ch_bit;
    end
    if (s1_word[13]) begin
      mixer_byte_next[5:3] = mixer_byte[5:3] & ~ch_bit;
    end else begin
      mixer_byte_next[5:3] = mixer_byte[5:3] | ch_bit;
    end
  end

  nwps_pitch u_pitch (
    .note_word   (s1_word),
    .transpose   (cfg.transpose[ch]),
    .tone_period (period)
  );

  nwps_level u_level (
    .vol_in (s1_word[11:8]),
    .level  (cfg.level[ch]),
    .volume (vol)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mixer_byte <= MIXER_RESET;
    end else if (load && !noise_cmd) begin
      mixer_byte <= mixer_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      settings_out.is_noise_cmd <= noise_cmd;
      settings_out.tone_period  <= noise_cmd ? 12'd0 : period;
      settings_out.volume       <= noise_cmd ? 4'd0 : vol;
      settings_out.mixer        <= noise_cmd ? mixer_byte : mixer_byte_next;
      settings_out.noise_period <= noise_cmd ? s1_word[7:0] : 8'd0;
    end
  end

  assign settings_out.valid = out_valid;

`ifndef NO_ASSERTIONS
  a_mixer_upper_clear: assert property (@(posedge clk) disable iff (rst)
    settings_out.valid |-> settings_out.mixer[7:6] == 2'b00)
    else $error("mixer bits above the noise enables are set");

  a_noise_fields: assert property (@(posedge clk) disable iff (rst)
    (settings_out.valid && settings_out.is_noise_cmd) |->
      (settings_out.tone_period == 12'd0 && settings_out.volume == 4'd0))
    else $error("noise item carries tone settings");

  a_tone_fields: assert property (@(posedge clk) disable iff (rst)
    (settings_out.valid && !settings_out.is_noise_cmd) |->
      settings_out.noise_period == 8'd0)
    else $error("tone item carries a noise period");

  a_mixer_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(load)) |-> $stable(mixer_byte))
    else $error("mixer byte changed without an item");

  a_mixer_match: assert property (@(posedge clk) disable iff (rst)
    $past(load) && !$past(rst) |-> settings_out.mixer == mixer_byte)
    else $error("result mixer differs from kept mixer byte");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// testbench for note_word_to_psg_settings: random and directed note items with
// a predictor and in-order check of settings items; apb register phases
// depends on nwps_pkg, nwps_if and the block's rtl
module testbench import nwps_pkg::*; ();

  localparam logic [1:0] CH_ALIAS = 2'd3;

  typedef struct packed {
    logic [1:0]  ch;
    logic [15:0] word;
  } note_item_t;

  typedef struct packed {
    logic        noise;
    logic [11:0] period;
    logic [3:0]  vol;
    logic [7:0]  mixer;
    logic [7:0]  noise_per;
  } psg_settings_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  nwps_note_if note_bus ();
  nwps_psg_if  psg_bus ();

  note_word_to_psg_settings i_dut (
    .clk          (clk),
    .rst          (rst),
    .note_in      (note_bus),
    .settings_out (psg_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  note_item_t        notes_waiting [$];
  psg_settings_t     settings_due [$];
  note_item_t        next_note;
  psg_settings_t     seen_settings;
  psg_settings_t     due_settings;

  logic signed [7:0] tr_model [3];
  logic [6:0]        lvl_model [3];
  logic [7:0]        mixer_model;

  int mismatches = 0;
  int hold_left = 0;
  bit stall_go = 1'b0;
  bit stall_done = 1'b0;
  bit calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("[note_word_to_psg_settings] ERROR");
    $finish;
  end

  function automatic psg_settings_t predict_settings(input logic [1:0] ch_in,
                                                     input logic [15:0] w);
    psg_settings_t r;
    int ch;
    int note;
    int semi;
    int frac;
    int vol;
    int period;
    logic [7:0] ch_bit;
    ch = int'((ch_in > CH_C) ? CH_C : ch_in);
    r = '0;
    if (w[15:14] == 2'b11) begin
      r.noise = 1'b1;
      r.mixer = mixer_model;
      r.noise_per = w[7:0];
      return r;
    end
    note = int'(w[7:2]);
    if (note > NOTE_LAST) note = NOTE_LAST;
    semi = int'(SCALE_TAB[note]);
    if (w[14]) semi = semi - 1;
    if (w[15]) semi = semi + 1;
    semi = semi - int'(tr_model[ch]);
    if (semi < 0) semi = 0;
    if (semi > SEMI_MAX) semi = SEMI_MAX;
    frac = int'(w[1:0]);
    period = (int'(PERIOD_TAB[semi]) * (4 - frac) + int'(PERIOD_TAB[semi + 1]) * frac) >> 2;
    r.period = 12'(period);
    ch_bit = 8'(1 << ch);
    if (w[12]) mixer_model = mixer_model & ~ch_bit;
    else mixer_model = mixer_model | ch_bit;
    if (w[13]) mixer_model = mixer_model & ~(ch_bit << 3);
    else mixer_model = mixer_model | (ch_bit << 3);
    vol = int'(w[11:8]) * int'(lvl_model[ch]) / 100;
    if (vol > 15) vol = 15;
    r.vol = 4'(vol);
    r.mixer = mixer_model;
    return r;
  endfunction

  function automatic logic [15:0] make_note(input bit sharp, input bit flat, input bit noise_on,
                                            input bit tone_on, input logic [3:0] vol,
                                            input logic [5:0] note, input logic [1:0] frac);
    return {sharp, flat, noise_on, tone_on, vol, note, frac};
  endfunction

  function automatic logic [15:0] random_note_word();
    logic [15:0] w;
    int pick;
    w = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 12) begin
      w[15:14] = 2'b11;
    end else if (pick < 75) begin
      w[15:14] = 2'($urandom_range(2));
      if ($urandom_range(3) != 0) w[7:2] = 6'($urandom_range(NOTE_LAST));
    end
    return w;
  endfunction

  task automatic queue_note(input logic [1:0] ch, input logic [15:0] w);
    note_item_t it;
    it.ch = ch;
    it.word = w;
    notes_waiting.push_back(it);
  endtask

  task automatic queue_random(input int n);
    logic [1:0] ch;
    for (int i = 0; i < n; i++) begin
      ch = ($urandom_range(9) == 0) ? CH_ALIAS : 2'($urandom_range(2));
      queue_note(ch, random_note_word());
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TRANSPOSE_A: tr_model[0] = val[7:0];
      REG_TRANSPOSE_B: tr_model[1] = val[7:0];
      REG_TRANSPOSE_C: tr_model[2] = val[7:0];
      REG_LEVEL_A:     lvl_model[0] = val[6:0];
      REG_LEVEL_B:     lvl_model[1] = val[6:0];
      REG_LEVEL_C:     lvl_model[2] = val[6:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [7:0] ta, input logic [7:0] tb, input logic [7:0] tc,
                           input logic [6:0] la, input logic [6:0] lb, input logic [6:0] lc);
    write_reg(REG_TRANSPOSE_A, {24'd0, ta});
    write_reg(REG_TRANSPOSE_B, {24'd0, tb});
    write_reg(REG_TRANSPOSE_C, {24'd0, tc});
    write_reg(REG_LEVEL_A, {25'd0, la});
    write_reg(REG_LEVEL_B, {25'd0, lb});
    write_reg(REG_LEVEL_C, {25'd0, lc});
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (notes_waiting.size() != 0 || note_bus.valid || settings_due.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      note_bus.valid <= 1'b0;
    end else if (!note_bus.valid || note_bus.ready) begin
      if (notes_waiting.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
        next_note = notes_waiting.pop_front();
        note_bus.valid <= 1'b1;
        note_bus.channel <= next_note.ch;
        note_bus.note_word <= next_note.word;
      end else begin
        note_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && note_bus.valid && note_bus.ready)
      settings_due.push_back(predict_settings(note_bus.channel, note_bus.note_word));
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      psg_bus.ready <= 1'b0;
    end else if (stall_go && !stall_done) begin
      hold_left <= 300;
      stall_done <= 1'b1;
      psg_bus.ready <= 1'b0;
    end else begin
      psg_bus.ready <= calm || $urandom_range(99) >= 28;
    end
  end

  always @(posedge clk) begin
    if (!rst && psg_bus.valid && psg_bus.ready) begin
      seen_settings = {psg_bus.is_noise_cmd, psg_bus.tone_period, psg_bus.volume,
                       psg_bus.mixer, psg_bus.noise_period};
      if (settings_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected settings item: noise=%0d period=%0d vol=%0d mixer=%02h nper=%02h",
                   seen_settings.noise, seen_settings.period, seen_settings.vol,
                   seen_settings.mixer, seen_settings.noise_per);
        mismatches++;
      end else begin
        due_settings = settings_due.pop_front();
        if (seen_settings.noise !== due_settings.noise ||
            seen_settings.period !== due_settings.period ||
            seen_settings.vol !== due_settings.vol ||
            seen_settings.mixer !== due_settings.mixer ||
            seen_settings.noise_per !== due_settings.noise_per) begin
          if (mismatches < 10) begin
            $display("mismatch expected: noise=%0d period=%0d vol=%0d mixer=%02h nper=%02h",
                     due_settings.noise, due_settings.period, due_settings.vol,
                     due_settings.mixer, due_settings.noise_per);
            $display("         actual:   noise=%0d period=%0d vol=%0d mixer=%02h nper=%02h",
                     seen_settings.noise, seen_settings.period, seen_settings.vol,
                     seen_settings.mixer, seen_settings.noise_per);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    note_bus.valid = 1'b0;
    note_bus.channel = '0;
    note_bus.note_word = '0;
    psg_bus.ready = 1'b0;
    for (int i = 0; i < 3; i++) begin
      tr_model[i] = 8'sd0;
      lvl_model[i] = 7'd100;
    end
    mixer_model = MIXER_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    queue_note(CH_A, make_note(0, 0, 1, 1, 4'd15, 6'd0, 2'd0));
    queue_note(CH_B, make_note(0, 0, 0, 1, 4'd15, 6'd56, 2'd3));
    queue_note(CH_C, make_note(0, 0, 1, 0, 4'd9, 6'd63, 2'd3));
    queue_note(CH_A, make_note(0, 0, 0, 1, 4'd4, 6'd57, 2'd1));
    queue_note(CH_A, make_note(0, 1, 1, 1, 4'd12, 6'd0, 2'd0));
    queue_note(CH_B, make_note(1, 0, 1, 1, 4'd12, 6'd56, 2'd0));
    queue_note(CH_C, make_note(1, 0, 0, 1, 4'd3, 6'd63, 2'd3));
    queue_note(CH_A, make_note(0, 1, 0, 0, 4'd6, 6'd56, 2'd2));
    queue_note(CH_A, 16'hC000);
    queue_note(CH_B, 16'hFFFF);
    queue_note(CH_ALIAS, 16'hC0A5);
    queue_note(CH_ALIAS, make_note(0, 0, 1, 1, 4'd7, 6'd30, 2'd2));
    queue_note(CH_A, make_note(0, 0, 0, 0, 4'd0, 6'd10, 2'd1));
    queue_note(CH_B, make_note(0, 0, 0, 1, 4'd1, 6'd20, 2'd2));
    queue_note(CH_C, make_note(0, 0, 0, 0, 4'd15, 6'd40, 2'd3));
    queue_note(CH_A, make_note(0, 0, 1, 0, 4'd8, 6'd1, 2'd3));
    queue_note(CH_B, 16'h0000);
    queue_note(CH_C, make_note(0, 0, 1, 1, 4'd15, 6'd63, 2'd3));
    queue_note(CH_A, make_note(0, 1, 1, 1, 4'd15, 6'd63, 2'd3));
    queue_note(CH_B, make_note(1, 0, 1, 1, 4'd15, 6'd63, 2'd3));
    queue_random(300);
    wait_drained();

    write_all(8'sd127, -8'sd128, 8'sd0, 7'd0, 7'd127, 7'd100);
    stall_go = 1'b1;
    queue_random(300);
    wait_drained();

    write_all(-8'sd96, 8'sd96, -8'sd1, 7'd100, 7'd1, 7'd50);
    calm = 1'b1;
    queue_random(300);
    wait_drained();
    calm = 1'b0;

    for (int p = 0; p < 3; p++) begin
      write_all(8'($urandom), 8'($urandom), 8'($urandom),
                7'($urandom_range(127)), 7'($urandom_range(100)), 7'($urandom_range(127)));
      queue_random(300);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[note_word_to_psg_settings] OK");
    end else begin
      $display("[note_word_to_psg_settings] ERROR");
    end
    $finish;
  end

endmodule
